>>> hdl/sao_pkg.sv
`default_nettype none
package sao_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int POOL_W    = 5;
	localparam int SLOT_W    = 4;
	localparam logic [POOL_W-1:0] POOL_RESET = 5'd16;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	typedef struct packed {
		logic load_req;
		logic scan_clr;
		logic scan_inc;
		logic grant;
		logic rel_clear;
		logic walk_start;
		logic walk_run;
		logic fin;
		logic res_fail;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic rel_hit;
		logic scan_end;
		logic scan_free;
		logic list_empty;
		logic walk_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> hdl/sao_ctrl.sv
`default_nettype none
module sao_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire sao_pkg::sts_t sts,
	output sao_pkg::cmd_t     cmd
);
	import sao_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_WALK   = 3'd3;
	localparam logic [2:0] ST_FIN    = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				priority if (sts.is_alloc) begin
					cmd.scan_clr = 1'b1;
					state_d      = ST_SCAN;
				end else if (sts.rel_hit) begin
					cmd.rel_clear  = 1'b1;
					cmd.walk_start = 1'b1;
					state_d        = ST_WALK;
				end else begin
					cmd.res_fail = 1'b1;
					state_d      = ST_DONE;
				end
			end
			ST_SCAN: begin
				priority if (sts.scan_end && sts.list_empty) begin
					cmd.res_fail = 1'b1;
					state_d      = ST_DONE;
				end else if (sts.scan_end) begin
					// no free slot: reclaim the head of the age list
					cmd.walk_start = 1'b1;
					state_d        = ST_WALK;
				end else if (sts.scan_free) begin
					cmd.grant = 1'b1;
					state_d   = ST_DONE;
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			ST_WALK: begin
				cmd.walk_run = 1'b1;
				if (sts.walk_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

>>> hdl/sao_dp.sv
`default_nettype none
module sao_dp #(
	parameter int SLOTS = sao_pkg::SLOTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wen,
	input  wire logic [sao_pkg::POOL_W-1:0]  cfg_wdata,
	input  wire logic                        func,
	input  wire logic [sao_pkg::SLOT_W-1:0]  slot,
	input  wire logic                        out_stall,
	output logic                             out_valid,
	output logic                             ok,
	output logic [sao_pkg::SLOT_W-1:0]       granted_slot,
	output logic                             recycled,
	input  wire sao_pkg::cmd_t               cmd,
	output sao_pkg::sts_t                    sts
);
	import sao_pkg::*;

	localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW   = $clog2(SLOTS + 1);
	localparam int CMPW = (CW > POOL_W) ? CW : POOL_W;

	logic [POOL_W-1:0] pool_q;
	logic [CMPW-1:0]   pool_eff;
	logic [SLOTS-1:0]  map_q;
	logic [CW-1:0]     count_q;
	logic              func_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CW-1:0]     scan_q;
	logic [IW-1:0]     key_q;
	logic [IW-1:0]     old_q;
	logic              first_q;
	logic              matched_q;
	logic [CW-1:0]     walk_q;
	logic              rd_valid_s1;
	logic [CW-1:0]     rd_pos_s1;
	logic [IW-1:0]     rdata_s1;
	logic              res_ok_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_rec_q;
	logic              out_valid_q;
	logic              ok_q;
	logic [SLOT_W-1:0] granted_q;
	logic              recycled_q;

	logic [IW-1:0] mem [SLOTS];

	logic [CMPW-1:0] slot_ext;
	logic [IW-1:0]   slot_idx;
	logic [IW-1:0]   scan_idx;
	logic [CMPW-1:0] scan_ext;
	logic [CMPW-1:0] old_ext;
	logic            old_in_pool;
	logic            walk_issue;
	logic            hit;
	logic            shift_wr;
	logic            mem_we;
	logic [IW-1:0]   mem_waddr;
	logic [IW-1:0]   mem_wdata;
	logic [CW-1:0]   shift_pos;
	logic [CW-1:0]   count_m1;

	always_comb begin
		if (CMPW'(pool_q) < CMPW'(SLOTS)) pool_eff = CMPW'(pool_q);
		else                              pool_eff = CMPW'(SLOTS);
	end

	assign slot_ext    = CMPW'(slot_q);
	assign slot_idx    = slot_ext[IW-1:0];
	assign scan_idx    = scan_q[IW-1:0];
	assign scan_ext    = CMPW'(scan_idx);
	assign old_ext     = CMPW'(old_q);
	assign old_in_pool = (old_ext < pool_eff);
	assign count_m1    = count_q - CW'(1);
	assign shift_pos   = rd_pos_s1 - CW'(1);

	assign walk_issue = cmd.walk_run && (walk_q < count_q);
	// the reclaim walk takes the head entry; the release walk looks for the key
	assign hit      = rd_valid_s1 && !matched_q && (first_q || (rdata_s1 == key_q));
	assign shift_wr = rd_valid_s1 && matched_q;

	assign sts.is_alloc   = (func_q == FUNC_ALLOC);
	assign sts.rel_hit    = (slot_ext < pool_eff) && map_q[slot_idx];
	assign sts.scan_end   = (CMPW'(scan_q) >= pool_eff);
	assign sts.scan_free  = !map_q[scan_idx];
	assign sts.list_empty = (count_q == '0);
	assign sts.walk_done  = (walk_q >= count_q) && !rd_valid_s1;
	assign sts.out_free   = !out_valid_q || !out_stall;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		priority if (cmd.grant) begin
			mem_we    = 1'b1;
			mem_waddr = count_q[IW-1:0];
			mem_wdata = scan_idx;
		end else if (shift_wr) begin
			mem_we    = 1'b1;
			mem_waddr = shift_pos[IW-1:0];
			mem_wdata = rdata_s1;
		end else if (cmd.fin && sts.is_alloc && old_in_pool) begin
			// count already includes the reclaimed entry, so it lands at the tail
			mem_we    = 1'b1;
			mem_waddr = count_m1[IW-1:0];
			mem_wdata = old_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_s1 <= mem[walk_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q      <= POOL_RESET;
			map_q       <= '0;
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) pool_q <= cfg_wdata;
			rd_valid_s1 <= walk_issue;
			if (cmd.grant) begin
				map_q[scan_idx] <= 1'b1;
				count_q         <= count_q + CW'(1);
			end
			if (cmd.rel_clear) map_q[slot_idx] <= 1'b0;
			if (cmd.fin) begin
				if (sts.is_alloc && old_in_pool) begin
					map_q[old_q] <= 1'b1;
				end else begin
					count_q <= count_m1;
					if (sts.is_alloc) map_q[old_q] <= 1'b0;
				end
			end
			if (cmd.out_load)    out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			func_q <= func;
			slot_q <= slot;
		end
		if (cmd.scan_clr)      scan_q <= '0;
		else if (cmd.scan_inc) scan_q <= scan_q + CW'(1);
		if (cmd.walk_start) begin
			walk_q    <= '0;
			matched_q <= 1'b0;
			first_q   <= sts.is_alloc;
			key_q     <= slot_idx;
		end else begin
			if (walk_issue) walk_q <= walk_q + CW'(1);
			if (hit) begin
				matched_q <= 1'b1;
				old_q     <= rdata_s1;
			end
		end
		rd_pos_s1 <= walk_q;
		if (cmd.res_fail) begin
			res_ok_q   <= 1'b0;
			res_slot_q <= '0;
			res_rec_q  <= 1'b0;
		end else if (cmd.grant) begin
			res_ok_q   <= 1'b1;
			res_slot_q <= scan_ext[SLOT_W-1:0];
			res_rec_q  <= 1'b0;
		end else if (cmd.fin) begin
			if (sts.is_alloc) begin
				res_ok_q   <= old_in_pool;
				res_slot_q <= old_in_pool ? old_ext[SLOT_W-1:0] : '0;
				res_rec_q  <= old_in_pool;
			end else begin
				res_ok_q   <= 1'b1;
				res_slot_q <= '0;
				res_rec_q  <= 1'b0;
			end
		end
		if (cmd.out_load) begin
			ok_q       <= res_ok_q;
			granted_q  <= res_slot_q;
			recycled_q <= res_rec_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign granted_slot = granted_q;
	assign recycled     = recycled_q;

endmodule
`default_nettype wire

>>> hdl/slot_allocator_oldest_reclaim.sv
// Slot allocator with oldest-first reclaim.
// Input channel (in_valid/in_stall): func selects allocate or release, slot
// names the slot to release. Output channel (out_valid/out_stall): one beat per
// request with ok, granted_slot and recycled.
// pool_size is written through cfg_wen/cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this. Steps,
// from the accepting edge to the load of the output register: an allocate that
// finds free slot k scans the map from slot 0 up to k; a release that hits walks
// the age list (one-read one-write memory, one entry per cycle) to remove its
// entry; an allocate that reclaims scans the whole pool first and then walks the
// list to take its head; a release that misses goes straight to the result. The
// block takes one request at a time: the next request is taken in the cycle
// after the output register is loaded.
// A new request is taken while the previous result still waits in the output
// register; a stalled receiver only holds the block in its last step.
// Reset clears the active map, the list count and the output valid, and sets
// pool_size to 16; the age list memory needs no clearing.
`default_nettype none
module slot_allocator_oldest_reclaim #(
	parameter int SLOTS = sao_pkg::SLOTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wen,
	input  wire logic [sao_pkg::POOL_W-1:0] cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       func,
	input  wire logic [sao_pkg::SLOT_W-1:0] slot,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            ok,
	output logic [sao_pkg::SLOT_W-1:0]      granted_slot,
	output logic                            recycled
);
	import sao_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sao_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sao_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.func         (func),
		.slot         (slot),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.ok           (ok),
		.granted_slot (granted_slot),
		.recycled     (recycled),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
`default_nettype wire

>>> tb/tb_slot_allocator_oldest_reclaim.sv
module tb_slot_allocator_oldest_reclaim;
	timeunit 1ns;
	timeprecision 1ps;

	import sao_pkg::*;

	localparam int SLOTS = SLOTS_DEF;
	localparam int ITEMS = 1850;
	localparam int LIMIT = 600000;
	localparam int SETTLE = SLOTS + 8;

	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] granted_slot;
		logic              recycled;
	} grant_t;

	class alloc_tracker;
		bit                busy[SLOTS];
		logic [SLOT_W-1:0] age_list[$];
		logic [POOL_W-1:0] pool_size;
		grant_t            grant_queue[$];
		int                errors;

		function new();
			pool_size = POOL_RESET;
			errors = 0;
		endfunction

		function void set_pool(logic [POOL_W-1:0] v);
			pool_size = v;
		endfunction

		function int pending();
			return grant_queue.size();
		endfunction

		// random slot currently held, or -1 when none is
		function int pick_busy();
			int cand[$];
			for (int i = 0; i < SLOTS; i++)
				if (busy[i]) cand.push_back(i);
			if (cand.size() == 0) return -1;
			return cand[$urandom_range(cand.size() - 1)];
		endfunction

		function void note_request(logic f, logic [SLOT_W-1:0] s);
			grant_t g;
			int     pool;
			int     oldest;
			bit     found;
			g = '0;
			found = 1'b0;
			pool = (pool_size > SLOTS) ? SLOTS : int'(pool_size);
			if (f == FUNC_ALLOC) begin
				for (int i = 0; i < pool && !found; i++) begin
					if (!busy[i]) begin
						busy[i] = 1'b1;
						age_list.push_back(SLOT_W'(i));
						g.ok = 1'b1;
						g.granted_slot = SLOT_W'(i);
						found = 1'b1;
					end
				end
				if (!found && age_list.size() > 0) begin
					oldest = int'(age_list.pop_front());
					if (oldest < pool) begin
						age_list.push_back(SLOT_W'(oldest));
						g.ok = 1'b1;
						g.granted_slot = SLOT_W'(oldest);
						g.recycled = 1'b1;
					end else begin
						// pool shrank under this slot: drop it, request fails
						busy[oldest] = 1'b0;
					end
				end
			end else if (s < pool && busy[s]) begin
				busy[s] = 1'b0;
				for (int i = 0; i < age_list.size(); i++) begin
					if (age_list[i] == s) begin
						age_list.delete(i);
						break;
					end
				end
				g.ok = 1'b1;
			end
			grant_queue.push_back(g);
		endfunction

		function void check_grant(grant_t act);
			grant_t exp_g;
			if (grant_queue.size() == 0) begin
				$error("result beat with no request pending: ok %0d granted_slot %0d recycled %0d",
					act.ok, act.granted_slot, act.recycled);
				errors++;
				return;
			end
			exp_g = grant_queue.pop_front();
			if (act.ok !== exp_g.ok) begin
				$error("ok mismatch: expected %0d, actual %0d", exp_g.ok, act.ok);
				errors++;
			end
			if (act.granted_slot !== exp_g.granted_slot) begin
				$error("granted_slot mismatch: expected %0d, actual %0d",
					exp_g.granted_slot, act.granted_slot);
				errors++;
			end
			if (act.recycled !== exp_g.recycled) begin
				$error("recycled mismatch: expected %0d, actual %0d", exp_g.recycled, act.recycled);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wen;
	logic [POOL_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_stall;
	logic              func;
	logic [SLOT_W-1:0] slot;
	logic              out_valid;
	logic              out_stall;
	logic              ok;
	logic [SLOT_W-1:0] granted_slot;
	logic              recycled;

	int           idle_pct;
	int           stall_pct;
	alloc_tracker tracker;

	slot_allocator_oldest_reclaim dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.slot         (slot),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.granted_slot (granted_slot),
		.recycled     (recycled)
	);

	always #5 clk = ~clk;

	// receiver stall and beat monitor
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		if (in_valid && !in_stall) tracker.note_request(func, slot);
		if (out_valid && !out_stall) tracker.check_grant(grant_t'({ok, granted_slot, recycled}));
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	task automatic send(logic f, logic [SLOT_W-1:0] s);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		slot <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_pool(logic [POOL_W-1:0] v);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tracker.set_pool(v);
	endtask

	task automatic random_request();
		int r;
		int b;
		r = $urandom_range(99);
		b = tracker.pick_busy();
		if (r < 55) send(FUNC_ALLOC, SLOT_W'($urandom_range(15)));
		else if (r < 85 && b >= 0) send(FUNC_RELEASE, SLOT_W'(b));
		else send(FUNC_RELEASE, SLOT_W'($urandom_range(15)));
	endtask

	function automatic logic [POOL_W-1:0] pick_pool();
		int r;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 20) return 5'd16;
		if (r < 30) return POOL_W'($urandom_range(31));
		return POOL_W'($urandom_range(6, 1));
	endfunction

	initial begin
		int sent;
		int n;
		tracker = new();
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		func = FUNC_ALLOC;
		slot = '0;
		out_stall = 1'b0;
		idle_pct = 22;
		stall_pct = 45;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full pool after reset: grants, release of idle slot, re-grant
		send(FUNC_RELEASE, 4'd15);
		send(FUNC_ALLOC, 4'd0);
		send(FUNC_ALLOC, 4'd0);
		send(FUNC_RELEASE, 4'd0);
		send(FUNC_ALLOC, 4'd0);
		send(FUNC_ALLOC, 4'd15);
		// shrink to two: reclaim oldest, then oldest lies outside the pool
		write_pool(5'd2);
		send(FUNC_ALLOC, 4'd0);
		send(FUNC_ALLOC, 4'd0);
		send(FUNC_ALLOC, 4'd0);
		send(FUNC_RELEASE, 4'd2);
		send(FUNC_RELEASE, 4'd1);
		// empty pool: drop leftover, then nothing to reclaim
		write_pool(5'd0);
		send(FUNC_ALLOC, 4'd0);
		send(FUNC_ALLOC, 4'd0);
		send(FUNC_RELEASE, 4'd0);
		// oversized setting clamps to the full pool
		write_pool(5'd31);
		send(FUNC_ALLOC, 4'd0);
		send(FUNC_RELEASE, 4'd15);
		send(FUNC_ALLOC, 4'd15);
		send(FUNC_RELEASE, 4'd1);
		send(FUNC_RELEASE, 4'd0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					idle_pct = 22;
					stall_pct = 45;
				end
				1: begin
					idle_pct = 45;
					stall_pct = 22;
				end
				default: begin
					idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < ITEMS / 3) begin
				write_pool(pick_pool());
				n = $urandom_range(90, 30);
				if (n > ITEMS / 3 - sent) n = ITEMS / 3 - sent;
				repeat (n) random_request();
				sent += n;
			end
		end

		drain();
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
